[rtl/core/bdq_pkg.sv]
package bdq_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd2;
  localparam logic [OP_W-1:0] OP_SEARCH     = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

[rtl/core/bdq_req_if.sv]
interface bdq_req_if
  import bdq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

[rtl/core/bdq_rsp_if.sv]
interface bdq_rsp_if
  import bdq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data;
  logic                     found;
  logic [POS_W-1:0]         position;
  logic [CNT_W-1:0]         count;

  modport source (output valid, output status, output data, output found,
                  output position, output count, input ready);
  modport sink   (input valid, input status, input data, input found,
                  input position, input count, output ready);
endinterface

[rtl/core/bdq_ram.sv]
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/bounded_deque_with_search_core.sv]
// Channel | Dir | Payload                                  | Handshake
// req     | in  | op, value                                | valid / ready
// rsp     | out | status, data, found, position, count     | valid / ready
//
// Pushes and failed requests load the result when accepted; a pop passes
// through S_POP, as the element RAM read is registered. A search reads one
// stored entry per cycle from the front, ending at the first match or the
// last entry. Reset is synchronous, leaving the deque empty; RAM contents are
// not cleared. One item is in flight at a time, and a new item is taken only
// when the result register is free or is being emptied in the same cycle.
module bounded_deque_with_search_core
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  bdq_req_if.sink    req,
  bdq_rsp_if.source  rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]        state;
  logic [AW-1:0]     front;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [DATA_W-1:0] key;

  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [DATA_W-1:0] out_data;
  logic              out_found;
  logic [POS_W-1:0]  out_position;
  logic [CNT_W-1:0]  out_count;

  logic              out_free;
  logic              out_load;
  logic              accept;
  logic              full;
  logic              empty;
  logic [CW-1:0]     count_inc;
  logic [CW-1:0]     count_dec;
  logic [CW-1:0]     idx_inc;
  logic [AW-1:0]     front_dec;
  logic [CW-1:0]     offset;
  logic [CW:0]       slot_sum;
  logic [AW-1:0]     slot;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_rdata;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign count_inc = count + 1'b1;
  assign count_dec = count - 1'b1;
  assign idx_inc   = idx + 1'b1;
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;

  // A result is loaded by every push, by a pop or search on an empty deque,
  // at the end of a pop, and at the end of a scan.
  assign out_load  = (state == S_POP) ||
                     (state == S_SCAN && ((ram_rdata == key) || (idx_inc == count))) ||
                     (accept && (req.op == OP_PUSH_FRONT || req.op == OP_PUSH_BACK ||
                                 empty));

  // Offset from the front of the entry to touch this cycle. While scanning,
  // the next entry is fetched as the current one is compared.
  always_comb begin
    offset = '0;
    if (state == S_SCAN) begin
      offset = idx_inc;
    end else begin
      unique case (req.op)
        OP_PUSH_BACK: offset = count;
        OP_POP_BACK:  offset = count_dec;
        default:      offset = '0;
      endcase
    end
  end

  // The sum stays below twice DEPTH, so one conditional subtract wraps it.
  always_comb begin
    slot_sum = (CW+1)'(front) + (CW+1)'(offset);
    if (slot_sum >= (CW+1)'(DEPTH)) begin
      slot_sum = slot_sum - (CW+1)'(DEPTH);
    end
    slot = slot_sum[AW-1:0];
  end

  assign ram_we    = accept && !full &&
                     (req.op == OP_PUSH_FRONT || req.op == OP_PUSH_BACK);
  assign ram_waddr = (req.op == OP_PUSH_FRONT) ? front_dec : slot;

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.value),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.op)
              OP_PUSH_FRONT, OP_PUSH_BACK: begin
                out_data     <= '0;
                out_found    <= 1'b0;
                out_position <= '0;
                if (full) begin
                  out_status <= STAT_FULL;
                  out_count  <= CNT_W'(count);
                end else begin
                  out_status <= STAT_OK;
                  out_count  <= CNT_W'(count_inc);
                  count      <= count_inc;
                  if (req.op == OP_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                end
              end
              OP_POP_BACK: begin
                if (empty) begin
                  out_status   <= STAT_EMPTY;
                  out_data     <= '0;
                  out_found    <= 1'b0;
                  out_position <= '0;
                  out_count    <= CNT_W'(count);
                end else begin
                  state <= S_POP;
                end
              end
              OP_SEARCH: begin
                if (empty) begin
                  out_status   <= STAT_OK;
                  out_data     <= '0;
                  out_found    <= 1'b0;
                  out_position <= '0;
                  out_count    <= CNT_W'(count);
                end else begin
                  key   <= req.value;
                  idx   <= '0;
                  state <= S_SCAN;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_POP: begin
          out_status   <= STAT_OK;
          out_data     <= ram_rdata;
          out_found    <= 1'b0;
          out_position <= '0;
          out_count    <= CNT_W'(count_dec);
          count        <= count_dec;
          state        <= S_IDLE;
        end
        S_SCAN: begin
          if (ram_rdata == key) begin
            out_status   <= STAT_OK;
            out_data     <= '0;
            out_found    <= 1'b1;
            out_position <= POS_W'(idx);
            out_count    <= CNT_W'(count);
            state        <= S_IDLE;
          end else if (idx_inc == count) begin
            out_status   <= STAT_OK;
            out_data     <= '0;
            out_found    <= 1'b0;
            out_position <= '0;
            out_count    <= CNT_W'(count);
            state        <= S_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.data     = out_data;
  assign rsp.found    = out_found;
  assign rsp.position = out_position;
  assign rsp.count    = out_count;

endmodule

[tb/sv/deque_check_pkg.sv]
`timescale 1ns / 1ps

package deque_check_pkg;
  import bdq_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } deque_result_t;

  // Mirrors the deque contents and holds the results still owed by the block.
  class deque_scoreboard;
    logic [DATA_W-1:0] ring [DEPTH_DEFAULT];
    int head;
    int fill;
    deque_result_t awaited[$];
    int mismatches;
    int results_seen;
    int requests_seen;
    int full_refusals;
    int empty_pops;
    int search_hits;
    int search_misses;
    int peak_fill;

    function new();
      head = 0;
      fill = 0;
      mismatches = 0;
      results_seen = 0;
      requests_seen = 0;
      full_refusals = 0;
      empty_pops = 0;
      search_hits = 0;
      search_misses = 0;
      peak_fill = 0;
    endfunction

    function int size();
      return fill;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic [DATA_W-1:0] value_at(int k);
      return ring[(head + k) % DEPTH_DEFAULT];
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
      deque_result_t r;
      r = '0;
      requests_seen++;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill >= DEPTH_DEFAULT) begin
            r.status = STAT_FULL;
            full_refusals++;
          end else if (op == OP_PUSH_FRONT) begin
            head = (head + DEPTH_DEFAULT - 1) % DEPTH_DEFAULT;
            ring[head] = value;
            fill++;
          end else begin
            ring[(head + fill) % DEPTH_DEFAULT] = value;
            fill++;
          end
        end
        OP_POP_BACK: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
            empty_pops++;
          end else begin
            r.data = ring[(head + fill - 1) % DEPTH_DEFAULT];
            fill--;
          end
        end
        default: begin
          for (int k = 0; k < fill; k++) begin
            if (ring[(head + k) % DEPTH_DEFAULT] == value) begin
              r.found = 1'b1;
              r.position = POS_W'(k);
              break;
            end
          end
          if (r.found) search_hits++;
          else search_misses++;
        end
      endcase
      if (fill > peak_fill) peak_fill = fill;
      r.count = CNT_W'(fill);
      awaited.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_result(deque_result_t got);
      deque_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status)
          report($sformatf("result %0d status got %0d expected %0d",
                           results_seen, got.status, want.status));
        if (got.data !== want.data)
          report($sformatf("result %0d data got 0x%08h expected 0x%08h",
                           results_seen, got.data, want.data));
        if (got.found !== want.found)
          report($sformatf("result %0d found got %0b expected %0b",
                           results_seen, got.found, want.found));
        if (got.position !== want.position)
          report($sformatf("result %0d position got %0d expected %0d",
                           results_seen, got.position, want.position));
        if (got.count !== want.count)
          report($sformatf("result %0d count got %0d expected %0d",
                           results_seen, got.count, want.count));
      end
    endtask
  endclass

endpackage

[tb/sv/bounded_deque_with_search_core_test.sv]
`timescale 1ns / 1ps

module bounded_deque_with_search_core_test;
  import bdq_pkg::*;
  import deque_check_pkg::*;

  localparam int TOTAL_ITEMS = 1300;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_WAIT    = 13;

  logic clk = 1'b0;
  logic rst;

  bdq_req_if req_ch ();
  bdq_rsp_if rsp_ch ();

  bounded_deque_with_search_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  deque_scoreboard book;
  bit req_idle_on = 1'b1;
  bit rsp_idle_on = 1'b1;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int draw_wait(bit on);
    return on ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  // Extremes and a small pool of values show up often so that duplicates
  // and first-match ordering get exercised.
  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return DATA_W'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_search_value();
    if (book.size() > 0 && $urandom_range(0, 2) != 0)
      return book.value_at($urandom_range(0, book.size() - 1));
    return random_value();
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
    int gap;
    gap = draw_wait(req_idle_on);
    repeat (gap) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= value;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Result side: stall a random number of cycles before each item.
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    do @(negedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_wait(rsp_idle_on);
      repeat (stall) begin
        rsp_ch.ready <= 1'b0;
        @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : monitor
    deque_result_t seen;
    bit moved;
    if (!rst) begin
      moved = 1'b0;
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.status   = rsp_ch.status;
        seen.data     = rsp_ch.data;
        seen.found    = rsp_ch.found;
        seen.position = rsp_ch.position;
        seen.count    = rsp_ch.count;
        book.check_result(seen);
        moved = 1'b1;
      end
      if (req_ch.valid && req_ch.ready) begin
        book.note_request(req_ch.op, req_ch.value);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, book.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int guard;
    logic [OP_W-1:0] op;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_PUSH_FRONT;
    req_ch.value = '0;
    book = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty cases, extreme values, first match among duplicates.
    send_request(OP_SEARCH, 32'h0000_0000);
    send_request(OP_POP_BACK, 32'h1234_5678);
    send_request(OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_PUSH_BACK, 32'h0000_0000);
    send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(OP_SEARCH, 32'h8000_0000);
    send_request(OP_SEARCH, 32'h0000_0000);
    send_request(OP_SEARCH, 32'h7FFF_FFFE);
    send_request(OP_SEARCH, 32'h7FFF_FFFF);
    send_request(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_request(OP_SEARCH, 32'hFFFF_FFFF);
    repeat (6) send_request(OP_POP_BACK, 32'hFFFF_FFFF);
    send_request(OP_PUSH_FRONT, 32'h0000_0005);
    send_request(OP_POP_BACK, 32'h0000_0000);

    // Random phases: fill to the top, drain to empty, or mix freely.
    while (book.requests_seen < TOTAL_ITEMS) begin
      req_idle_on = ($urandom_range(0, 3) != 0);
      rsp_idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0: begin
          guard = 0;
          while (book.size() < DEPTH_DEFAULT && guard < 300) begin
            guard++;
            if ($urandom_range(0, 6) == 0)
              send_request(OP_SEARCH, pick_search_value());
            else
              send_request($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                           random_value());
          end
          send_request(OP_PUSH_FRONT, random_value());
          send_request(OP_PUSH_BACK, random_value());
          // The entry at the back forces the longest scan when it is unique.
          send_request(OP_SEARCH, book.size() > 0 ? book.value_at(book.size() - 1)
                                                  : random_value());
        end
        1: begin
          guard = 0;
          while (book.size() > 0 && guard < 300) begin
            guard++;
            if ($urandom_range(0, 5) == 0)
              send_request(OP_SEARCH, pick_search_value());
            else
              send_request(OP_POP_BACK, random_value());
          end
          send_request(OP_POP_BACK, random_value());
        end
        default: begin
          repeat (60) begin
            op = OP_W'($urandom_range(0, 3));
            send_request(op, op == OP_SEARCH ? pick_search_value() : random_value());
          end
        end
      endcase
    end
    req_ch.valid <= 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (DEPTH_DEFAULT + 8) @(posedge clk);

    $display("Covered %0d requests and %0d results, deque fill reaching %0d of %0d.",
             book.requests_seen, book.results_seen, book.peak_fill, DEPTH_DEFAULT);
    $display("Refused pushes when full: %0d, pops from empty: %0d, search hits: %0d, misses: %0d.",
             book.full_refusals, book.empty_pops, book.search_hits, book.search_misses);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bdq_pkg.sv
rtl/core/bdq_req_if.sv
rtl/core/bdq_rsp_if.sv
rtl/core/bdq_ram.sv
rtl/core/bounded_deque_with_search_core.sv
tb/sv/deque_check_pkg.sv
tb/sv/bounded_deque_with_search_core_test.sv
